// File: rtl/core/mvae_pkg.sv
// Shared types, widths, register indexes and reset values for the envelope generator.
package mvae_pkg;

    localparam int LEVEL_W   = 24;
    localparam int TIMER_W   = 20;
    localparam int GAIN_W    = 16;
    localparam int SUST_W    = 16;
    localparam int VOICE_W   = 3;
    localparam int OUT_W     = 16;
    localparam int PHASE_W   = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 24;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 24;

    localparam int VOICES_DEFAULT = 8;

    localparam logic                RST_INPUT_ENABLED = 1'b1;
    localparam logic [TIMER_W-1:0]  RST_ATTACK_LEN    = TIMER_W'(24000);
    localparam logic [LEVEL_W-1:0]  RST_ATTACK_STEP   = LEVEL_W'(699);
    localparam logic [LEVEL_W-1:0]  RST_DECAY_STEP    = LEVEL_W'(699);
    localparam logic [LEVEL_W-1:0]  RST_RELEASE_STEP  = LEVEL_W'(350);
    localparam logic [SUST_W-1:0]   RST_SUSTAIN_LEVEL = SUST_W'(32768);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INPUT_ENABLED = 3'd0,
        REG_ATTACK_LEN    = 3'd1,
        REG_ATTACK_STEP   = 3'd2,
        REG_DECAY_STEP    = 3'd3,
        REG_RELEASE_STEP  = 3'd4,
        REG_SUSTAIN_LEVEL = 3'd5
    } cfg_index_t;

    typedef enum logic [PHASE_W-1:0] {
        PH_ATTACK   = 2'd0,
        PH_DECAY    = 2'd1,
        PH_RELEASE  = 2'd2,
        PH_DISABLED = 2'd3
    } phase_t;

    typedef struct packed {
        logic [TIMER_W-1:0] attack_len;
        logic [LEVEL_W-1:0] attack_step;
        logic [LEVEL_W-1:0] decay_step;
        logic [LEVEL_W-1:0] release_step;
    } env_cfg_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [TIMER_W-1:0] timer;
        logic               rearm;
    } voice_state_t;

endpackage

// File: rtl/core/mvae_update.sv
// Per-tick envelope update for one voice: phase choice, timer and clamped level step.
module mvae_update (
    input  mvae_pkg::env_cfg_t                 cfg,
    input  mvae_pkg::voice_state_t             cur,
    input  logic [mvae_pkg::GAIN_W-1:0]        gain,
    input  logic [mvae_pkg::LEVEL_W-1:0]       sustain_goal,
    output mvae_pkg::voice_state_t             nxt,
    output mvae_pkg::phase_t                   phase
);
    import mvae_pkg::*;

    localparam logic [TIMER_W-1:0] TIMER_MAX = '1;

    logic [TIMER_W-1:0] timer_eff;
    logic               in_attack;
    logic [LEVEL_W-1:0] goal;
    logic [LEVEL_W-1:0] step;
    logic [LEVEL_W-1:0] diff_up;
    logic [LEVEL_W-1:0] diff_dn;
    logic [LEVEL_W-1:0] level_next;

    assign timer_eff = cur.rearm ? '0 : cur.timer;
    assign in_attack = timer_eff < cfg.attack_len;

    always_comb
    begin
        if (gain == '0)
        begin
            goal  = '0;
            step  = cfg.release_step;
            phase = PH_RELEASE;
        end
        else if (in_attack)
        begin
            goal  = {gain, {(LEVEL_W-GAIN_W){1'b0}}};
            step  = cfg.attack_step;
            phase = PH_ATTACK;
        end
        else
        begin
            goal  = sustain_goal;
            step  = cfg.decay_step;
            phase = PH_DECAY;
        end
    end

    assign diff_up = goal - cur.level;
    assign diff_dn = cur.level - goal;

    // never step past the target
    always_comb
    begin
        if (goal > cur.level)
            level_next = (diff_up > step) ? cur.level + step : goal;
        else if (goal < cur.level)
            level_next = (diff_dn > step) ? cur.level - step : goal;
        else
            level_next = cur.level;
    end

    always_comb
    begin
        nxt.level = level_next;
        if (gain == '0)
        begin
            nxt.timer = cur.timer;
            nxt.rearm = 1'b1;
        end
        else
        begin
            nxt.timer = (timer_eff < TIMER_MAX) ? timer_eff + 1'b1 : timer_eff;
            nxt.rearm = 1'b0;
        end
    end

endmodule

// File: rtl/core/multi_voice_adsr_envelope_top.sv
// Path: stage-one request register, then the output register. Throughput: one
// request per cycle unless the master side stalls; stage one forms the sustain product,
// stage two reads, steps and writes back the voice state and loads the output register.
// Voice state sits in flip-flops, so back-to-back requests to one voice need no bypass.
// Reset (rst_n, asynchronous, active low) clears all voices to level zero, timer zero,
// not re-armed, and loads the configuration registers with their default values.
module multi_voice_adsr_envelope_top #(
    parameter int VOICES = mvae_pkg::VOICES_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [mvae_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mvae_pkg::CFG_W-1:0]           cfg_wdata,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [mvae_pkg::IN_TDATA_W-1:0]      s_tdata,  // voice[2:0], gate_gain[18:3]
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [mvae_pkg::OUT_TDATA_W-1:0]     m_tdata   // level[15:0], phase[17:16]
);
    import mvae_pkg::*;

    localparam int VIDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;

    logic               input_enabled_reg;
    logic [SUST_W-1:0]  sustain_level_reg;
    env_cfg_t           cfg_reg;

    logic               a_valid_reg;
    logic [VOICE_W-1:0] a_voice_reg;
    logic [GAIN_W-1:0]  a_gain_reg;
    logic [LEVEL_W-1:0] a_sust_reg;

    logic               out_valid_reg;
    logic [OUT_W-1:0]   out_level_reg;
    phase_t             out_phase_reg;

    logic [LEVEL_W-1:0] level_reg [VOICES];
    logic [TIMER_W-1:0] timer_reg [VOICES];
    logic               rearm_reg [VOICES];

    logic                         advance;
    logic                         accept;
    logic [VOICE_W-1:0]           in_voice;
    logic [GAIN_W-1:0]            in_gain;
    logic [SUST_W+GAIN_W-1:0]     sust_prod;
    logic [VIDX_W-1:0]            idx;
    logic                         voice_ok;
    logic                         live;
    voice_state_t                 cur_state;
    voice_state_t                 nxt_state;
    phase_t                       upd_phase;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            input_enabled_reg    <= RST_INPUT_ENABLED;
            cfg_reg.attack_len   <= RST_ATTACK_LEN;
            cfg_reg.attack_step  <= RST_ATTACK_STEP;
            cfg_reg.decay_step   <= RST_DECAY_STEP;
            cfg_reg.release_step <= RST_RELEASE_STEP;
            sustain_level_reg    <= RST_SUSTAIN_LEVEL;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_INPUT_ENABLED: input_enabled_reg    <= cfg_wdata[0];
                REG_ATTACK_LEN:    cfg_reg.attack_len   <= cfg_wdata[TIMER_W-1:0];
                REG_ATTACK_STEP:   cfg_reg.attack_step  <= cfg_wdata[LEVEL_W-1:0];
                REG_DECAY_STEP:    cfg_reg.decay_step   <= cfg_wdata[LEVEL_W-1:0];
                REG_RELEASE_STEP:  cfg_reg.release_step <= cfg_wdata[LEVEL_W-1:0];
                REG_SUSTAIN_LEVEL: sustain_level_reg    <= cfg_wdata[SUST_W-1:0];
                default: ;
            endcase
        end
    end

    // handshake
    assign advance  = a_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !a_valid_reg || advance;
    assign accept   = s_tvalid && s_tready;

    assign in_voice  = s_tdata[VOICE_W-1:0];
    assign in_gain   = s_tdata[VOICE_W +: GAIN_W];
    assign sust_prod = sustain_level_reg * in_gain;

    // stage one: request register with sustain target
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (s_tready)
            a_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_voice_reg <= in_voice;
            a_gain_reg  <= in_gain;
            a_sust_reg  <= sust_prod[SUST_W+GAIN_W-1 -: LEVEL_W];
        end
    end

    // stage two: voice state read, update and write back
    assign idx      = VIDX_W'(a_voice_reg);
    assign voice_ok = 32'(a_voice_reg) < VOICES;
    assign live     = input_enabled_reg && voice_ok;

    always_comb
    begin
        cur_state.level = level_reg[idx];
        cur_state.timer = timer_reg[idx];
        cur_state.rearm = rearm_reg[idx];
    end

    mvae_update u_update (
        .cfg          (cfg_reg),
        .cur          (cur_state),
        .gain         (a_gain_reg),
        .sustain_goal (a_sust_reg),
        .nxt          (nxt_state),
        .phase        (upd_phase)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < VOICES; i++)
            begin
                level_reg[i] <= '0;
                timer_reg[i] <= '0;
                rearm_reg[i] <= 1'b0;
            end
        end
        else if (advance && live)
        begin
            level_reg[idx] <= nxt_state.level;
            timer_reg[idx] <= nxt_state.timer;
            rearm_reg[idx] <= nxt_state.rearm;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_level_reg <= live ? nxt_state.level[LEVEL_W-1 -: OUT_W] : '0;
            out_phase_reg <= live ? upd_phase : PH_DISABLED;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W-OUT_W-PHASE_W){1'b0}}, out_phase_reg, out_level_reg};

`ifndef SYNTHESIS
    a_disabled_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_phase_reg == PH_DISABLED) |-> (out_level_reg == '0))
        else $error("disabled result carries a non-zero level");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (a_valid_reg && out_valid_reg && !m_tready))
        else $error("request side stalled with room in the pipeline");

    a_advance_loads: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("advanced request did not reach the output register");
`endif

endmodule
